/* rtl/core/fsc_pkg.sv */
// Shared types, constants and the expected fetch sequence for the fetch sequence checker.
`default_nettype none

package fsc_pkg;

	// Most reads a test may capture; a larger limit setting is clamped to this
	localparam int MAX_CAPTURE = 2048;
	// Default number of words in the expected fetch sequence
	localparam int SEQ_LENGTH_DEFAULT = 30;

	localparam int ADDR_W = 16;
	localparam int COUNT_W = 12;
	localparam int LIMIT_W = 12;
	// Widest sequence index the table function takes (up to 64 words)
	localparam int SEQ_IDX_W = 6;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2048;

	// Register indexes on the configuration port
	localparam logic REG_CAPTURE_LIMIT = 1'b0;

	// Sequence layout: a short run of low addresses, then a block at a fixed base
	localparam int SEQ_LOW_WORDS = 8;
	localparam logic [ADDR_W-1:0] SEQ_HIGH_BASE = 16'h11cb;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ARMED = 2'd1,
		PH_HELD  = 2'd2
	} phase_t;

	// Result of one finished test
	typedef struct packed {
		logic               ended_full;
		logic [COUNT_W-1:0] reads_counted;
		logic               sequence_found;
	} fsc_result_t;

	// Expected address of sequence element i
	function automatic logic [ADDR_W-1:0] seq_word(input logic [SEQ_IDX_W-1:0] i);
		logic [ADDR_W-1:0] w;
		if (i < SEQ_IDX_W'(SEQ_LOW_WORDS)) begin
			w = ADDR_W'(i);
		end else begin
			w = SEQ_HIGH_BASE + ADDR_W'(i) - ADDR_W'(SEQ_LOW_WORDS);
		end
		return w;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/fsc_engine.sv */
// Test control, read counting and sequence matcher; one bus sample per transfer.
`default_nettype none

module fsc_engine #(
	parameter int SEQ_LENGTH = fsc_pkg::SEQ_LENGTH_DEFAULT
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             sample_valid,
	input  wire                             run_level,
	input  wire                             mem_request_n,
	input  wire                             read_n,
	input  wire  [fsc_pkg::ADDR_W-1:0]      bus_address,
	input  wire  [fsc_pkg::LIMIT_W-1:0]     capture_limit,
	output logic                            res_valid,
	output fsc_pkg::fsc_result_t            res
);

	localparam int PROG_W = (SEQ_LENGTH > 1) ? $clog2(SEQ_LENGTH) : 1;

	fsc_pkg::phase_t             phase_q, phase_d;
	logic                        last_run_q;
	logic [fsc_pkg::COUNT_W-1:0] count_q, count_d;
	logic [PROG_W-1:0]           prog_q, prog_d;
	logic                        found_q, found_d;

	logic                        active;
	logic                        start;
	logic                        held;
	logic [fsc_pkg::COUNT_W-1:0] count_base;
	logic [PROG_W-1:0]           prog_base;
	logic                        found_base;
	logic                        hit;
	logic [PROG_W:0]             prog_next;
	logic [fsc_pkg::COUNT_W-1:0] count_inc;
	logic [fsc_pkg::LIMIT_W-1:0] eff_limit;

	// Clamp the limit setting into 1..MAX_CAPTURE
	always_comb begin
		if (capture_limit == '0) begin
			eff_limit = fsc_pkg::LIMIT_W'(1);
		end else if (17'(capture_limit) > 17'(fsc_pkg::MAX_CAPTURE)) begin
			eff_limit = fsc_pkg::LIMIT_W'(fsc_pkg::MAX_CAPTURE);
		end else begin
			eff_limit = capture_limit;
		end
	end

	// A rising run level starts a fresh test; a test in progress keeps its state
	assign active     = (phase_q == fsc_pkg::PH_ARMED) || (phase_q == fsc_pkg::PH_HELD);
	assign start      = !active && run_level && !last_run_q;
	assign held       = !start && (phase_q == fsc_pkg::PH_HELD);
	assign count_base = start ? '0 : count_q;
	assign prog_base  = start ? '0 : prog_q;
	assign found_base = start ? 1'b0 : found_q;
	assign count_inc  = count_base + fsc_pkg::COUNT_W'(1);

	// Advance through the sequence or restart at its first word
	assign hit = (bus_address == fsc_pkg::seq_word(fsc_pkg::SEQ_IDX_W'(prog_base)));
	always_comb begin
		if (hit) begin
			prog_next = (PROG_W+1)'(prog_base) + (PROG_W+1)'(1);
		end else if (bus_address == fsc_pkg::seq_word('0)) begin
			prog_next = (PROG_W+1)'(1);
		end else begin
			prog_next = '0;
		end
	end

	// Next state and result for the accepted sample
	always_comb begin
		phase_d   = phase_q;
		count_d   = count_base;
		prog_d    = prog_base;
		found_d   = found_base;
		res_valid = 1'b0;
		res.sequence_found = found_base;
		res.reads_counted  = count_base;
		res.ended_full     = 1'b0;
		if (!active && !start) begin
			phase_d = fsc_pkg::PH_IDLE;
		end else if (!run_level) begin
			res_valid = 1'b1;
			phase_d   = fsc_pkg::PH_IDLE;
		end else if (held) begin
			if (mem_request_n) begin
				phase_d = fsc_pkg::PH_ARMED;
			end else begin
				phase_d = fsc_pkg::PH_HELD;
			end
		end else if (!mem_request_n && !read_n) begin
			count_d = count_inc;
			if (prog_next >= (PROG_W+1)'(SEQ_LENGTH)) begin
				found_d = 1'b1;
				prog_d  = '0;
			end else begin
				prog_d  = prog_next[PROG_W-1:0];
			end
			if (count_inc >= eff_limit) begin
				res_valid = 1'b1;
				res.sequence_found = found_d;
				res.reads_counted  = count_inc;
				res.ended_full     = 1'b1;
				phase_d = fsc_pkg::PH_IDLE;
			end else begin
				phase_d = fsc_pkg::PH_HELD;
			end
		end else begin
			phase_d = fsc_pkg::PH_ARMED;
		end
	end

	// Update test state once per accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= fsc_pkg::PH_IDLE;
			last_run_q <= 1'b0;
			count_q    <= '0;
			prog_q     <= '0;
			found_q    <= 1'b0;
		end else if (sample_valid) begin
			phase_q    <= phase_d;
			last_run_q <= run_level;
			count_q    <= count_d;
			prog_q     <= prog_d;
			found_q    <= found_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/fetch_sequence_checker_top.sv */
// Top level of the fetch sequence checker: stream ports, register port and result buffer.
//
// Usage: each transfer on the s_ group is one bus sample (run level, memory request,
// read strobe, address). A test starts when the run level rises; every new memory
// read is counted and fed to a matcher that looks for the expected fetch sequence.
// When the run level falls, or the read count reaches capture_limit, one result
// transfer leaves on the m_ group with the found flag, the count and the full flag.
// Samples that end no test produce no result.
// A result from the ending sample is registered before it is shown on m_tvalid.
// Throughput: one sample per cycle while s_tready is high; the state update for a
// sample is one register stage. An output register plus a skid register let samples
// keep flowing while a result waits; s_tready drops only when both hold results.
// Reset: the test is idle, run level taken as low, capture_limit returns to 2048.
// The user writes capture_limit (APB-style port, address 0) only while idle; not enforced.
`default_nettype none

module fetch_sequence_checker_top #(
	parameter int SEQ_LENGTH = fsc_pkg::SEQ_LENGTH_DEFAULT
) (
	input  wire         clk,
	input  wire         arst_n,
	// sample stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // [0] run_level, [1] mem_request_n, [2] read_n,
	                               // [18:3] bus_address, [23:19] zero
	// result stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [0] sequence_found, [12:1] reads_counted,
	                               // [13] ended_full, [15:14] zero
	// register port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [fsc_pkg::LIMIT_W-1:0] limit_q;
	logic                        sample_valid;
	logic                        res_valid;
	fsc_pkg::fsc_result_t        res;
	logic                        out_valid_q;
	fsc_pkg::fsc_result_t        out_q;
	logic                        skid_valid_q;
	fsc_pkg::fsc_result_t        skid_q;

	// Register port: always ready, write on the access phase
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= fsc_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && pready
		             && paddr[2] == fsc_pkg::REG_CAPTURE_LIMIT) begin
			limit_q <= pwdata[fsc_pkg::LIMIT_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			fsc_pkg::REG_CAPTURE_LIMIT: prdata = 32'(limit_q);
			default:                    prdata = '0;
		endcase
	end

	// Sample path
	assign s_tready     = !skid_valid_q;
	assign sample_valid = s_tvalid && s_tready;

	fsc_engine #(
		.SEQ_LENGTH(SEQ_LENGTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.run_level    (s_tdata[0]),
		.mem_request_n(s_tdata[1]),
		.read_n       (s_tdata[2]),
		.bus_address  (s_tdata[18:3]),
		.capture_limit(limit_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	// Output register with skid: drain skid first, park a new result when stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q  <= skid_valid_q || (sample_valid && res_valid);
			skid_valid_q <= 1'b0;
		end else if (sample_valid && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (sample_valid && res_valid) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.ended_full, out_q.reads_counted, out_q.sequence_found};

endmodule

`default_nettype wire
